@@ src/polyline_line_rasterizer_assert.svh @@
// assertion macros for the rasterizer rtl, used by plr_ctrl
`ifndef POLYLINE_LINE_RASTERIZER_ASSERT_SVH
`define POLYLINE_LINE_RASTERIZER_ASSERT_SVH

// same-cycle implication
`define PLR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("rasterizer check failed");

// next-cycle implication
`define PLR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("rasterizer check failed");

`endif

@@ src/plr_pkg.sv @@
// ----------------------------------------------------------------------------
// plr_pkg
// Shared constants, emit selects and controller/datapath link types for the
// polyline line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package plr_pkg;

  localparam int COORD_BITS     = 12;
  localparam int SPAN_LIMIT_DEF = 63;

  // which cell the output register takes
  localparam logic [1:0] EMIT_WALK = 2'd0;
  localparam logic [1:0] EMIT_END  = 2'd1;
  localparam logic [1:0] EMIT_ERR  = 2'd2;

  typedef struct packed {
    logic       load;
    logic       setup;
    logic       step;
    logic       emit;
    logic [1:0] emit_sel;
    logic       commit;
  } plr_cmd_t;

  typedef struct packed {
    logic start;
    logic span_bad;
    logic at_tgt;
    logic step_done;
    logic last;
    logic out_free;
  } plr_sts_t;

endpackage

`default_nettype wire

@@ src/plr_point_if.sv @@
// ----------------------------------------------------------------------------
// plr_point_if
// Vertex channel: valid/ready handshake carrying one polyline vertex.
// ----------------------------------------------------------------------------
`default_nettype none

interface plr_point_if import plr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic                  first_vertex;
  logic                  last_vertex;

  modport source (output valid, output point_x, output point_y,
                  output first_vertex, output last_vertex, input ready);
  modport sink   (input valid, input point_x, input point_y,
                  input first_vertex, input last_vertex, output ready);
endinterface

`default_nettype wire

@@ src/plr_cell_if.sv @@
// ----------------------------------------------------------------------------
// plr_cell_if
// Cell channel: valid/ready handshake carrying one rasterized grid cell.
// ----------------------------------------------------------------------------
`default_nettype none

interface plr_cell_if import plr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] cell_x;
  logic [COORD_BITS-1:0] cell_y;
  logic                  run_last;
  logic                  path_end;
  logic                  span_error;

  modport source (output valid, output cell_x, output cell_y, output run_last,
                  output path_end, output span_error, input ready);
  modport sink   (input valid, input cell_x, input cell_y, input run_last,
                  input path_end, input span_error, output ready);
endinterface

`default_nettype wire

@@ src/plr_datapath.sv @@
// ----------------------------------------------------------------------------
// plr_datapath
// Vertex registers, Bresenham error-term stepper and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module plr_datapath import plr_pkg::*; #(
  parameter int SPAN_LIMIT = SPAN_LIMIT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire plr_cmd_t              cmd,
  output plr_sts_t                   sts,
  input  wire logic [COORD_BITS-1:0] pt_x,
  input  wire logic [COORD_BITS-1:0] pt_y,
  input  wire logic                  pt_first,
  input  wire logic                  pt_last,
  output logic                       cell_valid,
  input  wire logic                  cell_ready,
  output logic [COORD_BITS-1:0]      cell_x,
  output logic [COORD_BITS-1:0]      cell_y,
  output logic                       cell_run_last,
  output logic                       cell_path_end,
  output logic                       cell_span_error
);

  localparam int SPAN_W = $clog2(SPAN_LIMIT + 1);
  localparam int ERR_W  = SPAN_W + 3;

  // walking position doubles as the previous vertex between items
  logic [COORD_BITS-1:0] cur_x_r, cur_y_r, cur_x_nxt, cur_y_nxt;
  logic [COORD_BITS-1:0] tgt_x_r, tgt_y_r;
  logic                  first_r, last_r, have_prev_r;
  logic signed [ERR_W-1:0] dx_r, dy_r, err_r, err_nxt;
  logic                  sx_neg_r, sy_neg_r;

  logic [COORD_BITS-1:0] adx, ady;
  logic signed [ERR_W-1:0] adx_s, ady_s, e2;
  logic                  step_x, step_y;

  logic                  out_valid_r;
  logic [COORD_BITS-1:0] out_x_r, out_y_r;
  logic                  out_run_last_r, out_path_end_r, out_span_error_r;

  always_comb begin
    adx   = (tgt_x_r > cur_x_r) ? tgt_x_r - cur_x_r : cur_x_r - tgt_x_r;
    ady   = (tgt_y_r > cur_y_r) ? tgt_y_r - cur_y_r : cur_y_r - tgt_y_r;
    adx_s = signed'({{(ERR_W-SPAN_W){1'b0}}, adx[SPAN_W-1:0]});
    ady_s = signed'({{(ERR_W-SPAN_W){1'b0}}, ady[SPAN_W-1:0]});
    e2     = err_r <<< 1;
    step_x = (e2 >= dy_r);
    step_y = (e2 <= dx_r);
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    if (step_x) begin
      cur_x_nxt = sx_neg_r ? cur_x_r - COORD_BITS'(1) : cur_x_r + COORD_BITS'(1);
    end
    if (step_y) begin
      cur_y_nxt = sy_neg_r ? cur_y_r - COORD_BITS'(1) : cur_y_r + COORD_BITS'(1);
    end
    err_nxt = err_r + (step_x ? dy_r : ERR_W'(0)) + (step_y ? dx_r : ERR_W'(0));
  end

  always_comb begin
    sts.start     = first_r || !have_prev_r;
    sts.span_bad  = (adx > COORD_BITS'(SPAN_LIMIT)) || (ady > COORD_BITS'(SPAN_LIMIT));
    sts.at_tgt    = (cur_x_r == tgt_x_r) && (cur_y_r == tgt_y_r);
    sts.step_done = (cur_x_nxt == tgt_x_r) && (cur_y_nxt == tgt_y_r);
    sts.last      = last_r;
    sts.out_free  = !out_valid_r || cell_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      have_prev_r <= 1'b0;
    end else if (cmd.commit) begin
      cur_x_r     <= tgt_x_r;
      cur_y_r     <= tgt_y_r;
      have_prev_r <= !last_r;
    end else if (cmd.step) begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tgt_x_r <= pt_x;
      tgt_y_r <= pt_y;
      first_r <= pt_first;
      last_r  <= pt_last;
    end
    if (cmd.setup) begin
      dx_r     <= adx_s;
      dy_r     <= -ady_s;
      err_r    <= adx_s - ady_s;
      sx_neg_r <= (tgt_x_r < cur_x_r);
      sy_neg_r <= (tgt_y_r < cur_y_r);
    end else if (cmd.step) begin
      err_r <= err_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (cell_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.emit_sel)
        EMIT_WALK: begin
          out_x_r          <= cur_x_r;
          out_y_r          <= cur_y_r;
          out_run_last_r   <= sts.step_done && !last_r;
          out_path_end_r   <= 1'b0;
          out_span_error_r <= 1'b0;
        end
        EMIT_ERR: begin
          out_x_r          <= tgt_x_r;
          out_y_r          <= tgt_y_r;
          out_run_last_r   <= 1'b1;
          out_path_end_r   <= last_r;
          out_span_error_r <= 1'b1;
        end
        default: begin
          out_x_r          <= tgt_x_r;
          out_y_r          <= tgt_y_r;
          out_run_last_r   <= 1'b1;
          out_path_end_r   <= 1'b1;
          out_span_error_r <= 1'b0;
        end
      endcase
    end
  end

  assign cell_valid      = out_valid_r;
  assign cell_x          = out_x_r;
  assign cell_y          = out_y_r;
  assign cell_run_last   = out_run_last_r;
  assign cell_path_end   = out_path_end_r;
  assign cell_span_error = out_span_error_r;

endmodule

`default_nettype wire

@@ src/plr_ctrl.sv @@
// ----------------------------------------------------------------------------
// plr_ctrl
// Sequencer: takes a vertex, sets up the line, walks it one cell per cycle while
// the output register has room, and issues a path's end cell or an error cell.
// ----------------------------------------------------------------------------
`default_nettype none

`include "polyline_line_rasterizer_assert.svh"

module plr_ctrl import plr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output plr_cmd_t      cmd,
  input  wire plr_sts_t sts
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_END   = 3'd3;
  localparam logic [2:0] S_ERR   = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.emit_sel = EMIT_WALK;
    in_ready     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        if (sts.start) begin
          if (sts.last) begin
            state_nxt = S_END;
          end else begin
            cmd.commit = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else if (sts.span_bad) begin
          state_nxt = S_ERR;
        end else if (sts.at_tgt) begin
          if (sts.last) begin
            state_nxt = S_END;
          end else begin
            cmd.commit = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.step = 1'b1;
          if (sts.step_done) begin
            if (sts.last) begin
              state_nxt = S_END;
            end else begin
              cmd.step   = 1'b0;
              cmd.commit = 1'b1;
              state_nxt  = S_IDLE;
            end
          end
        end
      end
      S_END: begin
        cmd.emit_sel = EMIT_END;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_ERR: begin
        cmd.emit_sel = EMIT_ERR;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `PLR_ASSERT_NEXT(a_load_to_setup, clk, rst_n, state_r == S_IDLE && in_valid, state_r == S_SETUP)
  `PLR_ASSERT_IMPL(a_emit_needs_room, clk, rst_n, cmd.emit, sts.out_free)
  `PLR_ASSERT_NEXT(a_walk_holds, clk, rst_n, state_r == S_WALK && !(cmd.emit && sts.step_done), state_r == S_WALK)
  `PLR_ASSERT_NEXT(a_close_to_idle, clk, rst_n, (state_r == S_END || state_r == S_ERR) && cmd.emit, state_r == S_IDLE)

endmodule

`default_nettype wire

@@ src/polyline_line_rasterizer.sv @@
// flow: an accepted vertex is set up in the cycle after acceptance; its cells then
// enter the output register from the walk of the stepper
// throughput: the next vertex is taken only once the previous one is finished, as the
// stepper walks one cell per cycle into the single output register while it has room
// reset: rst_n synchronous, active low; clears the held vertex to (0,0), no previous vertex
// ----------------------------------------------------------------------------
// polyline_line_rasterizer
// Top level: Bresenham rasterizer for a stream of polyline vertices.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_line_rasterizer import plr_pkg::*; #(
  parameter int SPAN_LIMIT = SPAN_LIMIT_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  plr_point_if.sink    in_ch,
  plr_cell_if.source   out_ch
);

  plr_cmd_t cmd;
  plr_sts_t sts;

  plr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  plr_datapath #(
    .SPAN_LIMIT (SPAN_LIMIT)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .pt_x            (in_ch.point_x),
    .pt_y            (in_ch.point_y),
    .pt_first        (in_ch.first_vertex),
    .pt_last         (in_ch.last_vertex),
    .cell_valid      (out_ch.valid),
    .cell_ready      (out_ch.ready),
    .cell_x          (out_ch.cell_x),
    .cell_y          (out_ch.cell_y),
    .cell_run_last   (out_ch.run_last),
    .cell_path_end   (out_ch.path_end),
    .cell_span_error (out_ch.span_error)
  );

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for polyline_line_rasterizer. Sends polyline vertices through the
// vertex channel and checks every emitted cell against a behavioral walk of
// the Bresenham lines, including path ends, repeated vertices and overlong
// segments, under random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb import plr_pkg::*; ();

  localparam int SPAN        = SPAN_LIMIT_DEF;
  localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  first;
    logic                  last;
  } vertex_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  run_last;
    logic                  path_end;
    logic                  span_error;
  } cell_t;

  logic clk;
  logic rst_n;

  plr_point_if in_ch ();
  plr_cell_if  out_ch ();

  polyline_line_rasterizer #(.SPAN_LIMIT(SPAN)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor state: held vertex of the current path
  logic [COORD_BITS-1:0] held_x;
  logic [COORD_BITS-1:0] held_y;
  logic                  held_valid;

  cell_t pending_cells[$];

  int  errors;
  int  cycle_count;
  int  vertices_sent;
  int  cells_checked;
  int  span_errors_seen;
  int  path_ends_seen;
  int  hold_reqs;
  bit  no_idle;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d cells still pending", $time,
               cycle_count, pending_cells.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic cell_t mk_cell(input int x, input int y, input bit pend,
                                    input bit serr);
    cell_t c;
    c.x          = x[COORD_BITS-1:0];
    c.y          = y[COORD_BITS-1:0];
    c.run_last   = 1'b0;
    c.path_end   = pend;
    c.span_error = serr;
    return c;
  endfunction

  // cells one accepted vertex produces, appended to the pending list
  task automatic rasterize_vertex(input vertex_t v);
    cell_t run[$];
    int    cx, cy, nx, ny, adx, ady, sx, sy, err, e2;
    nx = v.x;
    ny = v.y;
    if (v.first || !held_valid) begin
      if (v.last) run.insert(run.size(), mk_cell(nx, ny, 1'b1, 1'b0));
    end else begin
      cx  = held_x;
      cy  = held_y;
      adx = (nx > cx) ? nx - cx : cx - nx;
      ady = (ny > cy) ? ny - cy : cy - ny;
      if (adx > SPAN || ady > SPAN) begin
        run.insert(run.size(), mk_cell(nx, ny, v.last, 1'b1));
      end else begin
        sx  = (cx < nx) ? 1 : -1;
        sy  = (cy < ny) ? 1 : -1;
        err = adx - ady;
        // the new vertex itself is left out of the walk
        while (!(cx == nx && cy == ny) && run.size() < SPAN) begin
          e2 = 2 * err;
          run.insert(run.size(), mk_cell(cx, cy, 1'b0, 1'b0));
          if (e2 >= -ady) begin
            err -= ady;
            cx  += sx;
          end
          if (e2 <= adx) begin
            err += adx;
            cy  += sy;
          end
        end
        if (v.last) run.insert(run.size(), mk_cell(nx, ny, 1'b1, 1'b0));
      end
    end
    if (run.size() > 0) run[run.size()-1].run_last = 1'b1;
    foreach (run[i]) pending_cells.insert(pending_cells.size(), run[i]);
    held_x     = v.x;
    held_y     = v.y;
    held_valid = !v.last;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : cell_check
    cell_t got;
    cell_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.cell_x, out_ch.cell_y, out_ch.run_last, out_ch.path_end,
              out_ch.span_error};
      if (got.span_error) span_errors_seen++;
      if (got.path_end) path_ends_seen++;
      if (pending_cells.size() == 0) begin
        $display("%0t: unexpected cell (%0d,%0d), nothing expected", $time,
                 got.x, got.y);
        errors++;
      end else begin
        want = pending_cells.pop_front();
        check_field("cell_x", want.x, got.x);
        check_field("cell_y", want.y, got.y);
        check_field("run_last", want.run_last, got.run_last);
        check_field("path_end", want.path_end, got.path_end);
        check_field("span_error", want.span_error, got.span_error);
        cells_checked++;
      end
    end
  end

  // cell channel ready: random stalls, or a long hold-off on request
  initial begin : cell_ready_drive
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(99) >= 12);
      end
    end
  end

  // one vertex transaction; prediction runs once it is accepted
  task automatic send_vertex(input int x, input int y, input bit first,
                             input bit last);
    vertex_t v;
    v.x     = x[COORD_BITS-1:0];
    v.y     = y[COORD_BITS-1:0];
    v.first = first;
    v.last  = last;
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 12) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.point_x      <= v.x;
    in_ch.point_y      <= v.y;
    in_ch.first_vertex <= v.first;
    in_ch.last_vertex  <= v.last;
    do @(posedge clk); while (!in_ch.ready);
    rasterize_vertex(v);
    vertices_sent++;
  endtask

  function automatic int clamp_coord(input int c);
    if (c < 0) return 0;
    if (c > COORD_MAX) return COORD_MAX;
    return c;
  endfunction

  function automatic int rand_offset(input int mag);
    int m;
    m = int'($urandom_range(mag));
    return $urandom_range(1) ? m : -m;
  endfunction

  task automatic test_single_vertex();
    send_vertex(0, 0, 1'b1, 1'b1);
    // last with no vertex held
    send_vertex(COORD_MAX, COORD_MAX, 1'b0, 1'b1);
  endtask

  task automatic test_directions();
    send_vertex(2048, 2048, 1'b1, 1'b0);
    send_vertex(2058, 2051, 1'b0, 1'b0);
    send_vertex(2055, 2062, 1'b0, 1'b0);
    send_vertex(2040, 2058, 1'b0, 1'b0);
    send_vertex(2036, 2040, 1'b0, 1'b0);
    send_vertex(2046, 2040, 1'b0, 1'b0);
    send_vertex(2046, 2050, 1'b0, 1'b0);
    send_vertex(2056, 2040, 1'b0, 1'b0);
    send_vertex(2056, 2040, 1'b0, 1'b0);
  endtask

  task automatic test_span_limit();
    send_vertex(100, 100, 1'b1, 1'b0);
    send_vertex(100 + SPAN, 100, 1'b0, 1'b0);
    send_vertex(100 + SPAN, 101 + SPAN, 1'b0, 1'b0);
    send_vertex(100, 101 + SPAN, 1'b0, 1'b0);
    // too far and last: error cell carries the path end
    send_vertex(0, 0, 1'b0, 1'b1);
  endtask

  task automatic test_path_breaks();
    send_vertex(COORD_MAX, 0, 1'b1, 1'b0);
    send_vertex(COORD_MAX - 5, 5, 1'b0, 1'b0);
    send_vertex(COORD_MAX - 5, 5, 1'b0, 1'b1);
    // no first flag, but the previous path has ended
    send_vertex(4000, 10, 1'b0, 1'b0);
    send_vertex(4010, 12, 1'b0, 1'b0);
    send_vertex(0, COORD_MAX, 1'b1, 1'b0);
    send_vertex(SPAN, COORD_MAX - SPAN, 1'b0, 1'b1);
  endtask

  // long segments while the cell channel is held off
  task automatic test_output_stall();
    int px, py;
    px = 500;
    py = 500;
    hold_reqs++;
    send_vertex(px, py, 1'b1, 1'b0);
    for (int k = 0; k < 10; k++) begin
      px = clamp_coord(px + rand_offset(SPAN));
      py = clamp_coord(py + rand_offset(SPAN));
      send_vertex(px, py, 1'b0, k == 9);
    end
  endtask

  task automatic test_random_paths(input int target);
    int sent, len, px, py, kind;
    bit closed;
    sent = 0;
    while (sent < target) begin
      no_idle = (sent < 60);
      if ($urandom_range(99) < 15) begin
        send_vertex($urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
        sent++;
      end else begin
        len    = $urandom_range(2, 8);
        px     = $urandom_range(COORD_MAX);
        py     = $urandom_range(COORD_MAX);
        closed = $urandom_range(99) < 90;
        send_vertex(px, py, 1'b1, 1'b0);
        sent++;
        for (int k = 1; k < len; k++) begin
          kind = $urandom_range(99);
          if (kind < 70) begin
            px += rand_offset(12);
            py += rand_offset(12);
          end else if (kind < 80) begin
            px += rand_offset(SPAN);
            py += rand_offset(SPAN);
          end else if (kind < 88) begin
            // repeated vertex
          end else if (kind < 95) begin
            px += ($urandom_range(1) ? 1 : -1) * int'($urandom_range(SPAN + 1, 300));
            py += rand_offset(300);
          end else begin
            px = $urandom_range(COORD_MAX);
            py = $urandom_range(COORD_MAX);
          end
          px = clamp_coord(px);
          py = clamp_coord(py);
          send_vertex(px, py, $urandom_range(99) < 3, closed && k == len - 1);
          sent++;
        end
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    errors           = 0;
    cycle_count      = 0;
    vertices_sent    = 0;
    cells_checked    = 0;
    span_errors_seen = 0;
    path_ends_seen   = 0;
    hold_reqs        = 0;
    no_idle          = 1'b0;
    held_x           = '0;
    held_y           = '0;
    held_valid       = 1'b0;

    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.point_x      = '0;
    in_ch.point_y      = '0;
    in_ch.first_vertex = 1'b0;
    in_ch.last_vertex  = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_single_vertex();
    test_directions();
    test_span_limit();
    test_path_breaks();
    test_output_stall();
    test_random_paths(345);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (SPAN + 8) @(posedge clk);

    if (pending_cells.size() != 0) begin
      $display("%0t: %0d expected cells never arrived", $time, pending_cells.size());
      errors++;
    end
    $display("run covered %0d vertices and %0d checked cells", vertices_sent,
             cells_checked);
    $display("span errors seen: %0d, path ends seen: %0d, mismatches: %0d",
             span_errors_seen, path_ends_seen, errors);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/plr_pkg.sv
src/plr_point_if.sv
src/plr_cell_if.sv
src/plr_datapath.sv
src/plr_ctrl.sv
src/polyline_line_rasterizer.sv
bench/tb.sv
